FILE: rtl/laplacian_sharpen_rgb_stream_top_defines.svh
// Assertion macros shared by the sharpening block.
// Both macros expect i_clk and i_rst_n in the scope where they are used.
`ifndef LAPLACIAN_SHARPEN_RGB_STREAM_TOP_DEFINES_SVH
`define LAPLACIAN_SHARPEN_RGB_STREAM_TOP_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define LSR_ASSERT_NOW(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// When the trigger holds, the consequence must hold at the next clock edge.
`define LSR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/lsr_pkg.sv
`timescale 1ns / 1ps
package lsr_pkg;

    localparam int CH_W  = 8;
    localparam int PIX_W = 3 * CH_W;
    localparam int CFG_DW = 11;
    localparam int CFG_IW = 2;

    // Register map of the configuration port.
    typedef enum logic [CFG_IW-1:0] {
        CFG_GRAY_MODE      = 2'd0,
        CFG_SHARPEN_ENABLE = 2'd1,
        CFG_IMAGE_WIDTH    = 2'd2,
        CFG_IMAGE_HEIGHT   = 2'd3
    } t_cfg_idx;

    // Meaning of the input tuser bit.
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic              RST_GRAY_MODE      = 1'b0;
    localparam logic              RST_SHARPEN_ENABLE = 1'b1;
    localparam logic [CFG_DW-1:0] RST_IMAGE_WIDTH    = 11'd640;
    localparam logic [CFG_DW-1:0] RST_IMAGE_HEIGHT   = 11'd480;

    // Luma weights in 2.14 fixed point; they sum to exactly 1.0.
    localparam int LUMA_SUM_W = 22;
    localparam logic [LUMA_SUM_W-1:0] LUMA_W0    = 22'd4899;
    localparam logic [LUMA_SUM_W-1:0] LUMA_W1    = 22'd9617;
    localparam logic [LUMA_SUM_W-1:0] LUMA_W2    = 22'd1868;
    localparam logic [LUMA_SUM_W-1:0] LUMA_ROUND = 22'd8192;

    // Control bits that travel with a word through the read stage.
    typedef struct packed {
        logic is_drain;
        logic produce;
        logic sharp;
        logic eof;
    } t_s1_ctrl;

    // The weights sum to 16384, so the rounded luma never exceeds 255.
    function automatic logic [CH_W-1:0] luma(input logic [PIX_W-1:0] px);
        logic [LUMA_SUM_W-1:0] sum;
        sum = LUMA_W0 * LUMA_SUM_W'(px[7:0]) + LUMA_W1 * LUMA_SUM_W'(px[15:8])
            + LUMA_W2 * LUMA_SUM_W'(px[23:16]) + LUMA_ROUND;
        return sum[LUMA_SUM_W-1:14];
    endfunction

    // One channel of the stencil: p + clamp(4p - up - down - left - right), clamped.
    function automatic logic [CH_W-1:0] sharpen_ch(
        input logic [CH_W-1:0] p,
        input logic [CH_W-1:0] u,
        input logic [CH_W-1:0] d,
        input logic [CH_W-1:0] l,
        input logic [CH_W-1:0] r
    );
        logic signed [11:0] lap;
        logic [CH_W-1:0]    lap_c;
        logic [CH_W:0]      sum;
        lap = ($signed({4'b0000, p}) <<< 2) - $signed({4'b0000, u})
            - $signed({4'b0000, d}) - $signed({4'b0000, l}) - $signed({4'b0000, r});
        if (lap < 0) begin
            lap_c = '0;
        end else if (lap > 12'sd255) begin
            lap_c = '1;
        end else begin
            lap_c = lap[CH_W-1:0];
        end
        sum = {1'b0, p} + {1'b0, lap_c};
        return sum[CH_W] ? {CH_W{1'b1}} : sum[CH_W-1:0];
    endfunction

endpackage

FILE: rtl/lsr_ram.sv
`timescale 1ns / 1ps
module lsr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/laplacian_sharpen_rgb_stream_top.sv
`timescale 1ns / 1ps
// Throughput: one word per clock on the input; a stall on the output only stops the input
// once both the read stage and the output register hold results.
// A result passes from the word that releases it through the line-store read into the read stage,
// then through the stencil into the output register; a stalled output holds it in the read stage.
// Reset: synchronous, active low; counters, flags, valid bits and configuration registers are reset.
// The line stores are not cleared and need no clearing pass after reset.
`include "laplacian_sharpen_rgb_stream_top_defines.svh"
module laplacian_sharpen_rgb_stream_top
    import lsr_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration write channel.
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data,
    // Input stream.
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [PIX_W-1:0]  s_axis_tdata,  // in_ch0 [7:0], in_ch1 [15:8], in_ch2 [23:16]
    input  logic              s_axis_tuser,  // command: 0 pixel, 1 drain tick
    // Output stream.
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [PIX_W-1:0]  m_axis_tdata,  // out_ch0 [7:0], out_ch1 [15:8], out_ch2 [23:16]
    output logic              m_axis_tlast   // end_of_frame
);

    // Column and drain counters index the line stores; the size widths also hold the maximum.
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int SW  = $clog2(MAX_WIDTH + 1);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int RSW = $clog2(MAX_HEIGHT + 1);

    // ------------------------------------------------------------------
    // Configuration registers. The port never stalls.
    // ------------------------------------------------------------------
    logic              r_gray_mode;
    logic              r_sharpen_enable;
    logic [CFG_DW-1:0] r_image_width;
    logic [CFG_DW-1:0] r_image_height;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gray_mode      <= RST_GRAY_MODE;
            r_sharpen_enable <= RST_SHARPEN_ENABLE;
            r_image_width    <= RST_IMAGE_WIDTH;
            r_image_height   <= RST_IMAGE_HEIGHT;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_GRAY_MODE:      r_gray_mode      <= i_cfg_data[0];
                CFG_SHARPEN_ENABLE: r_sharpen_enable <= i_cfg_data[0];
                CFG_IMAGE_WIDTH:    r_image_width    <= i_cfg_data;
                CFG_IMAGE_HEIGHT:   r_image_height   <= i_cfg_data;
            endcase
        end
    end

    // Frame sizes as used, limited to 3 up to MAX_WIDTH (the store depth) and MAX_HEIGHT.
    logic [SW-1:0]  w_eff;
    logic [RSW-1:0] h_eff;

    always_comb begin
        if (r_image_width < CFG_DW'(3)) begin
            w_eff = SW'(3);
        end else if (32'(r_image_width) > MAX_WIDTH) begin
            w_eff = SW'(MAX_WIDTH);
        end else begin
            w_eff = SW'(r_image_width);
        end
        if (r_image_height < CFG_DW'(3)) begin
            h_eff = RSW'(3);
        end else if (32'(r_image_height) > MAX_HEIGHT) begin
            h_eff = RSW'(MAX_HEIGHT);
        end else begin
            h_eff = RSW'(r_image_height);
        end
    end

    // ------------------------------------------------------------------
    // Accept side: frame position counters. All control decisions for a
    // word are made here, in the cycle it is accepted, and ride along
    // with it into the read stage.
    // ------------------------------------------------------------------
    logic [CW-1:0] r_col;
    logic [CW-1:0] n_col;
    logic [RW-1:0] r_row;
    logic [RW-1:0] n_row;
    logic [CW-1:0] r_drain;
    logic [CW-1:0] n_drain;
    logic          r_draining;
    logic          n_draining;

    logic     s_acc;
    logic     pix_ok;
    logic     drain_ok;
    logic     col_last;
    logic     row_last;
    logic     drain_last;
    logic     s1_adv;
    t_s1_ctrl s0_ctrl;

    assign s_acc    = s_axis_tvalid && s_axis_tready;
    // A pixel while draining and a drain tick outside draining are swallowed.
    assign pix_ok   = s_acc && (s_axis_tuser == CMD_PIXEL) && !r_draining;
    assign drain_ok = s_acc && (s_axis_tuser == CMD_DRAIN) && r_draining;

    assign col_last   = (SW'(r_col) + SW'(1)) >= w_eff;
    assign row_last   = (RSW'(r_row) + RSW'(1)) >= h_eff;
    assign drain_last = (SW'(r_drain) + SW'(1)) >= w_eff;

    always_comb begin
        s0_ctrl.is_drain = drain_ok;
        // The first row of a frame only fills the line store.
        s0_ctrl.produce  = drain_ok || (r_row >= RW'(1));
        // Interior pixels only: the top and bottom rows, and the first and
        // last columns, pass through.
        s0_ctrl.sharp    = r_sharpen_enable && (r_row >= RW'(2)) && (r_col != '0) && !col_last;
        s0_ctrl.eof      = drain_ok && drain_last;
    end

    always_comb begin
        n_col      = r_col;
        n_row      = r_row;
        n_drain    = r_drain;
        n_draining = r_draining;
        if (drain_ok) begin
            if (drain_last) begin
                n_draining = 1'b0;
                n_drain    = '0;
                n_row      = '0;
                n_col      = '0;
            end else begin
                n_drain = r_drain + CW'(1);
            end
        end else if (pix_ok) begin
            if (col_last) begin
                n_col = '0;
                if (row_last) begin
                    n_draining = 1'b1;
                    n_drain    = '0;
                end else begin
                    n_row = r_row + RW'(1);
                end
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_drain    <= '0;
            r_draining <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_drain    <= n_drain;
            r_draining <= n_draining;
        end
    end

    // ------------------------------------------------------------------
    // Line stores. The older row holds row r-2, the previous row holds
    // row r-1; a second copy of the previous row serves the right
    // neighbor read at column c+1. Reads are issued with the accept, so
    // the data lines up with the word in the read stage. A word writes
    // column c as it leaves the read stage, and the next word reads
    // column c+1, so a read never meets the write of the same entry.
    // ------------------------------------------------------------------
    logic             r_s1_valid;
    t_s1_ctrl         r_s1_ctrl;
    logic [CW-1:0]    r_s1_addr;
    logic [PIX_W-1:0] r_s1_in;
    logic [PIX_W-1:0] r_left;

    logic [CW-1:0]    prev_rd_addr;
    logic [PIX_W-1:0] q_center;
    logic [PIX_W-1:0] q_up;
    logic [PIX_W-1:0] q_right;
    logic [PIX_W-1:0] s1_px;
    logic             st_wr;

    assign prev_rd_addr = drain_ok ? r_drain : r_col;
    assign st_wr        = s1_adv && !r_s1_ctrl.is_drain;

    lsr_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_prev_ram (
        .i_clk     (i_clk),
        .i_wr_en   (st_wr),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (s1_px),
        .i_rd_en   (s_acc),
        .i_rd_addr (prev_rd_addr),
        .o_rd_data (q_center)
    );

    lsr_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_prev_right_ram (
        .i_clk     (i_clk),
        .i_wr_en   (st_wr),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (s1_px),
        .i_rd_en   (s_acc),
        .i_rd_addr (r_col + CW'(1)),
        .o_rd_data (q_right)
    );

    lsr_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older_ram (
        .i_clk     (i_clk),
        .i_wr_en   (st_wr),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (q_center),
        .i_rd_en   (s_acc),
        .i_rd_addr (r_col),
        .o_rd_data (q_up)
    );

    // ------------------------------------------------------------------
    // Read stage: the word waits here with its store data. It moves on
    // when it makes no result or the output register has room.
    // ------------------------------------------------------------------
    logic r_out_valid;

    assign s1_adv = r_s1_valid
                 && (!r_s1_ctrl.produce || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (pix_ok || drain_ok) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_ok || drain_ok) begin
            r_s1_ctrl <= s0_ctrl;
            r_s1_addr <= r_col;
            r_s1_in   <= s_axis_tdata;
        end
    end

    // The left neighbor is the center of the pixel before this one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (st_wr) begin
            r_left <= q_center;
        end
    end

    // Gray conversion of the arriving pixel, which is the lower neighbor.
    logic [CH_W-1:0] s1_luma;

    assign s1_luma = luma(r_s1_in);
    assign s1_px   = r_gray_mode ? {s1_luma, s1_luma, s1_luma} : r_s1_in;

    logic [PIX_W-1:0] s1_res;

    always_comb begin
        s1_res = q_center;
        if (!r_s1_ctrl.is_drain && r_s1_ctrl.sharp) begin
            for (int k = 0; k < 3; k++) begin
                s1_res[k*CH_W +: CH_W] = sharpen_ch(q_center[k*CH_W +: CH_W],
                                                    q_up[k*CH_W +: CH_W],
                                                    s1_px[k*CH_W +: CH_W],
                                                    r_left[k*CH_W +: CH_W],
                                                    q_right[k*CH_W +: CH_W]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] r_out_data;
    logic             r_out_last;
    logic             out_load;

    assign out_load = s1_adv && r_s1_ctrl.produce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= s1_res;
            r_out_last <= r_s1_ctrl.eof;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `LSR_ASSERT_NOW(a_drain_col_zero, !r_draining || (r_col == '0),
        "column counter not at zero while draining")

    `LSR_ASSERT_NOW(a_ready_when_empty, r_s1_valid || s_axis_tready,
        "input stalled with an empty read stage")

    `LSR_ASSERT_NEXT(a_frame_end_drains, pix_ok && col_last && row_last, r_draining,
        "last pixel of a frame did not start draining")

    `LSR_ASSERT_NEXT(a_drain_end_restarts, drain_ok && drain_last,
        !r_draining && (r_row == '0) && (r_drain == '0),
        "last drain tick did not restart the frame")

endmodule
